[rtl/cpt_pkg.sv]
`default_nettype none
// ============================================================================
// cpt_pkg
// Shared sizes, field codes and status codes of the capability permission
// table.
// ============================================================================
package cpt_pkg;

    localparam int SERVICES    = 16;
    localparam int CAPS        = 64;
    localparam int AUDIT_DEPTH = 16;
    localparam int MAX_RESULTS = 64;

    localparam int SVC_IDX_W = (SERVICES > 1) ? $clog2(SERVICES) : 1;
    localparam int AUD_IDX_W = (AUDIT_DEPTH > 1) ? $clog2(AUDIT_DEPTH) : 1;

    localparam logic [63:0] CAP_FIELD_MASK = {64{1'b1}} >> (64 - CAPS);

    localparam logic [2:0] KIND_ACTIVATE   = 3'd0;
    localparam logic [2:0] KIND_DEACTIVATE = 3'd1;
    localparam logic [2:0] KIND_GRANT      = 3'd2;
    localparam logic [2:0] KIND_REVOKE     = 3'd3;
    localparam logic [2:0] KIND_CHECK      = 3'd4;
    localparam logic [2:0] KIND_AUDIT_READ = 3'd5;
    localparam logic [2:0] KIND_CNT_READ   = 3'd6;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_DENIED  = 2'd2;

    localparam int CNT_W = 3;
    localparam int NUM_CNT = 7;
    localparam logic [CNT_W-1:0] CNT_CHECKS   = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ALLOWED  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_DENIED   = 3'd2;
    localparam logic [CNT_W-1:0] CNT_ACTIVATE = 3'd3;
    localparam logic [CNT_W-1:0] CNT_DEACT    = 3'd4;
    localparam logic [CNT_W-1:0] CNT_REVOKE   = 3'd5;
    localparam logic [CNT_W-1:0] CNT_TOTAL    = 3'd6;

endpackage
`default_nettype wire

[rtl/cpt_if.sv]
`default_nettype none
// ============================================================================
// cpt_if
// Request and response channels of the capability permission table.
// ============================================================================
interface cpt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  service;
    logic [6:0]  cap;
    logic [63:0] mask;
    logic [6:0]  max_entries;
    logic [2:0]  counter_select;

    modport source (output valid, kind, service, cap, mask, max_entries, counter_select,
                    input ready);
    modport sink   (input valid, kind, service, cap, mask, max_entries, counter_select,
                    output ready);
endinterface

interface cpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  entry_service;
    logic [5:0]  entry_cap;
    logic        entry_allowed;
    logic        entry_revoked;
    logic [31:0] entry_seq;
    logic        entry_valid;
    logic [31:0] counter_value;
    logic        last;

    modport source (output valid, status, entry_service, entry_cap, entry_allowed,
                    entry_revoked, entry_seq, entry_valid, counter_value, last,
                    input ready);
    modport sink   (input valid, status, entry_service, entry_cap, entry_allowed,
                    entry_revoked, entry_seq, entry_valid, counter_value, last,
                    output ready);
endinterface
`default_nettype wire

[rtl/capability_permission_table_top.sv]
`default_nettype none
// ============================================================================
// capability_permission_table_top
// Per-service capability masks with checks, an audit ring and statistics.
// ============================================================================
// Requests arrive on req and results leave on rsp; a beat moves on a clock
// edge where valid and ready are both high. One request is handled at a time.
// A request is decoded and applied in the cycle after its beat, and its result
// is then written to the output register; the first entry of an audit read
// is written from the audit state that follows.
// Counting uses a single shared 32-bit incrementer, one counter per cycle:
// activate, deactivate and a revoke that clears a bit bump one counter, a
// check bumps three (check count, allowed or denied count, audit total), and
// grant, other revokes, rejected requests and reads bump none.
// An audit read streams its entries one beat per cycle while rsp is ready.
// The next request beat is taken once the block is idle and the output
// register is empty or being emptied in that cycle.
// A stalled receiver holds the current result and pauses the audit stream.
// Reset clears all masks, active flags, the audit ring and every counter.
// ============================================================================
module capability_permission_table_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cpt_req_if.sink    req,
    cpt_rsp_if.source  rsp
);

    typedef struct packed {
        logic [7:0]  service;
        logic [5:0]  cap;
        logic        allowed;
        logic        revoked;
        logic [31:0] seq;
    } audit_entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_service;
        logic [5:0]  entry_cap;
        logic        entry_allowed;
        logic        entry_revoked;
        logic [31:0] entry_seq;
        logic        entry_valid;
        logic [31:0] counter_value;
        logic        last;
    } result_t;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_INC   = 2'd2;
    localparam logic [1:0] S_AUDIT = 2'd3;

    localparam logic [cpt_pkg::AUD_IDX_W-1:0] AUD_LAST =
        cpt_pkg::AUD_IDX_W'(cpt_pkg::AUDIT_DEPTH - 1);

    logic [1:0] state_reg, state_next;

    logic [2:0]  kind_reg;
    logic [7:0]  svc_reg;
    logic [6:0]  cap_reg;
    logic [63:0] mask_reg;
    logic [6:0]  maxe_reg;
    logic [2:0]  sel_reg;

    logic [63:0]        masks_reg [cpt_pkg::SERVICES];
    logic [63:0]        masks_next [cpt_pkg::SERVICES];
    logic [cpt_pkg::SERVICES-1:0] active_reg, active_next;
    audit_entry_t       ring_reg [cpt_pkg::AUDIT_DEPTH];
    audit_entry_t       ring_next [cpt_pkg::AUDIT_DEPTH];
    logic [cpt_pkg::AUD_IDX_W-1:0] head_reg, head_next;
    logic [31:0]        cnt_reg [cpt_pkg::NUM_CNT];
    logic [31:0]        cnt_next [cpt_pkg::NUM_CNT];
    logic [cpt_pkg::NUM_CNT-1:0] pend_reg, pend_next;

    logic [cpt_pkg::AUD_IDX_W-1:0] aud_idx_reg, aud_idx_next;
    logic [6:0] aud_k_reg, aud_k_next;
    logic [6:0] aud_n_reg, aud_n_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic                          accept;
    logic                          out_free;
    logic                          svc_ok;
    logic                          both_ok;
    logic [cpt_pkg::SVC_IDX_W-1:0] svc_idx;
    logic [63:0]                   cap_bit;
    logic                          cur_act;
    logic [63:0]                   cur_mask;
    logic                          chk_ok;
    logic [6:0]                    want;
    logic [6:0]                    aud_n;
    logic [31:0]                   total;
    logic [cpt_pkg::CNT_W-1:0]     inc_idx;
    logic [31:0]                   inc_sum;
    logic [cpt_pkg::NUM_CNT-1:0]   pend_left;
    logic                          aud_last;
    result_t                       res;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign svc_ok   = {1'b0, svc_reg} < 9'(cpt_pkg::SERVICES);
    assign both_ok  = svc_ok && ({1'b0, cap_reg} < 8'(cpt_pkg::CAPS));
    assign svc_idx  = svc_reg[cpt_pkg::SVC_IDX_W-1:0];
    assign cap_bit  = 64'(1) << cap_reg[5:0];
    assign cur_act  = active_reg[svc_idx];
    assign cur_mask = masks_reg[svc_idx];
    assign chk_ok   = cur_act && ((cur_mask & cap_bit) != 64'd0);
    assign total    = cnt_reg[cpt_pkg::CNT_TOTAL];
    assign want     = (maxe_reg > 7'(cpt_pkg::MAX_RESULTS)) ? 7'(cpt_pkg::MAX_RESULTS)
                                                            : maxe_reg;
    assign aud_n    = ({25'd0, want} < total) ? want : total[6:0];
    assign aud_last = (aud_k_reg + 7'd1) == aud_n_reg;

    always_comb
    begin
        inc_idx = '0;
        for (int i = cpt_pkg::NUM_CNT - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                inc_idx = cpt_pkg::CNT_W'(i);
            end
        end
    end

    assign inc_sum   = cnt_reg[inc_idx] + 32'd1;
    assign pend_left = pend_reg & ~(cpt_pkg::NUM_CNT'(1) << inc_idx);

    always_comb
    begin
        state_next     = state_reg;
        masks_next     = masks_reg;
        active_next    = active_reg;
        ring_next      = ring_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        aud_idx_next   = aud_idx_reg;
        aud_k_next     = aud_k_reg;
        aud_n_next     = aud_n_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        res            = '0;
        res.last       = 1'b1;
        res.status     = cpt_pkg::STATUS_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                pend_next = '0;
                case (kind_reg)
                    cpt_pkg::KIND_ACTIVATE:
                    begin
                        if (!svc_ok || ((mask_reg & ~cpt_pkg::CAP_FIELD_MASK) != 64'd0))
                        begin
                            res.status = cpt_pkg::STATUS_INVALID;
                        end
                        else
                        begin
                            masks_next[svc_idx]                  = mask_reg;
                            active_next[svc_idx]                 = 1'b1;
                            pend_next[cpt_pkg::CNT_ACTIVATE]     = 1'b1;
                        end
                    end
                    cpt_pkg::KIND_DEACTIVATE:
                    begin
                        if (!svc_ok)
                        begin
                            res.status = cpt_pkg::STATUS_INVALID;
                        end
                        else
                        begin
                            masks_next[svc_idx]              = 64'd0;
                            active_next[svc_idx]             = 1'b0;
                            pend_next[cpt_pkg::CNT_DEACT]    = 1'b1;
                        end
                    end
                    cpt_pkg::KIND_GRANT:
                    begin
                        if (!both_ok)
                        begin
                            res.status = cpt_pkg::STATUS_INVALID;
                        end
                        else if (!cur_act)
                        begin
                            res.status = cpt_pkg::STATUS_DENIED;
                        end
                        else
                        begin
                            masks_next[svc_idx] = cur_mask | cap_bit;
                        end
                    end
                    cpt_pkg::KIND_REVOKE:
                    begin
                        if (!both_ok)
                        begin
                            res.status = cpt_pkg::STATUS_INVALID;
                        end
                        else if (!cur_act)
                        begin
                            res.status = cpt_pkg::STATUS_DENIED;
                        end
                        else if ((cur_mask & cap_bit) != 64'd0)
                        begin
                            masks_next[svc_idx]            = cur_mask & ~cap_bit;
                            pend_next[cpt_pkg::CNT_REVOKE] = 1'b1;
                        end
                    end
                    cpt_pkg::KIND_CHECK:
                    begin
                        if (!both_ok)
                        begin
                            res.status = cpt_pkg::STATUS_INVALID;
                        end
                        else
                        begin
                            pend_next[cpt_pkg::CNT_CHECKS] = 1'b1;
                            pend_next[cpt_pkg::CNT_TOTAL]  = 1'b1;
                            if (chk_ok)
                            begin
                                pend_next[cpt_pkg::CNT_ALLOWED] = 1'b1;
                            end
                            else
                            begin
                                pend_next[cpt_pkg::CNT_DENIED] = 1'b1;
                                res.status                     = cpt_pkg::STATUS_DENIED;
                            end
                            ring_next[head_reg] = '{service: svc_reg,
                                                    cap:     cap_reg[5:0],
                                                    allowed: chk_ok,
                                                    revoked: !cur_act,
                                                    seq:     total};
                            head_next = (head_reg == AUD_LAST) ? '0
                                        : head_reg + cpt_pkg::AUD_IDX_W'(1);
                        end
                    end
                    cpt_pkg::KIND_AUDIT_READ:
                    begin
                        if (maxe_reg == 7'd0)
                        begin
                            res.status = cpt_pkg::STATUS_INVALID;
                        end
                        else if (aud_n != 7'd0)
                        begin
                            aud_n_next   = aud_n;
                            aud_k_next   = 7'd0;
                            aud_idx_next = (head_reg == '0) ? AUD_LAST
                                           : head_reg - cpt_pkg::AUD_IDX_W'(1);
                        end
                    end
                    cpt_pkg::KIND_CNT_READ:
                    begin
                        if (sel_reg > cpt_pkg::CNT_REVOKE)
                        begin
                            res.status = cpt_pkg::STATUS_INVALID;
                        end
                        else
                        begin
                            res.counter_value = cnt_reg[sel_reg];
                        end
                    end
                    default:
                    begin
                        res.status = cpt_pkg::STATUS_INVALID;
                    end
                endcase

                if ((kind_reg == cpt_pkg::KIND_AUDIT_READ) && (maxe_reg != 7'd0)
                    && (aud_n != 7'd0))
                begin
                    state_next = S_AUDIT;
                end
                else
                begin
                    out_next       = res;
                    out_valid_next = 1'b1;
                    state_next     = (pend_next != '0) ? S_INC : S_IDLE;
                end
            end
            S_INC:
            begin
                cnt_next[inc_idx] = inc_sum;
                pend_next         = pend_left;
                if (pend_left == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            S_AUDIT:
            begin
                if (out_free)
                begin
                    res.entry_service = ring_reg[aud_idx_reg].service;
                    res.entry_cap     = ring_reg[aud_idx_reg].cap;
                    res.entry_allowed = ring_reg[aud_idx_reg].allowed;
                    res.entry_revoked = ring_reg[aud_idx_reg].revoked;
                    res.entry_seq     = ring_reg[aud_idx_reg].seq;
                    res.entry_valid   = 1'b1;
                    res.last          = aud_last;
                    out_next          = res;
                    out_valid_next    = 1'b1;
                    aud_k_next        = aud_k_reg + 7'd1;
                    aud_idx_next      = (aud_idx_reg == '0) ? AUD_LAST
                                        : aud_idx_reg - cpt_pkg::AUD_IDX_W'(1);
                    if (aud_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            active_reg    <= '0;
            head_reg      <= '0;
            pend_reg      <= '0;
            for (int i = 0; i < cpt_pkg::SERVICES; i++)
            begin
                masks_reg[i] <= '0;
            end
            for (int i = 0; i < cpt_pkg::AUDIT_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            for (int i = 0; i < cpt_pkg::NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            head_reg      <= head_next;
            pend_reg      <= pend_next;
            masks_reg     <= masks_next;
            ring_reg      <= ring_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req.kind;
            svc_reg  <= req.service;
            cap_reg  <= req.cap;
            mask_reg <= req.mask;
            maxe_reg <= req.max_entries;
            sel_reg  <= req.counter_select;
        end
        aud_idx_reg <= aud_idx_next;
        aud_k_reg   <= aud_k_next;
        aud_n_reg   <= aud_n_next;
        out_reg     <= out_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.entry_service = out_reg.entry_service;
    assign rsp.entry_cap     = out_reg.entry_cap;
    assign rsp.entry_allowed = out_reg.entry_allowed;
    assign rsp.entry_revoked = out_reg.entry_revoked;
    assign rsp.entry_seq     = out_reg.entry_seq;
    assign rsp.entry_valid   = out_reg.entry_valid;
    assign rsp.counter_value = out_reg.counter_value;
    assign rsp.last          = out_reg.last;

endmodule
`default_nettype wire

[rtl/cpt_checker.sv]
`default_nettype none
// ============================================================================
// cpt_checker
// Port-level checks of the capability permission table, bound to the top.
// ============================================================================
module cpt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [1:0]  status,
    input wire logic [7:0]  entry_service,
    input wire logic [31:0] entry_seq,
    input wire logic        entry_valid,
    input wire logic [31:0] counter_value,
    input wire logic        last
);

    // One request at a time: a beat closes the request port for the next cycle.
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request port stayed open after a request beat");

    a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && entry_valid |-> status == cpt_pkg::STATUS_OK && counter_value == 32'd0)
        else $error("audit entry beat with nonzero status or counter");

    a_plain_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !entry_valid |-> last && entry_seq == 32'd0 && entry_service == 8'd0)
        else $error("non-entry result is not a clean single beat");

    // An audit stream continues without a gap once the receiver takes a beat.
    a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !last |=> rsp_valid)
        else $error("audit stream broke before its last beat");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(last)
                                    && $stable(entry_seq))
        else $error("stalled result changed");

endmodule

bind capability_permission_table_top cpt_checker u_cpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .entry_service (rsp.entry_service),
    .entry_seq     (rsp.entry_seq),
    .entry_valid   (rsp.entry_valid),
    .counter_value (rsp.counter_value),
    .last          (rsp.last)
);
`default_nettype wire
